// ----- rtl/glv_pkg.sv -----
// ----------------------------------------------------------------------------
// glv_pkg
// Shared constants, types and helpers of the scalar splitter.
// ----------------------------------------------------------------------------
package glv_pkg;

  // group order r and (r - 1) / 2
  localparam logic [255:0] ORD_R  =
    256'h3FFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_9D0C930F54078C53_1F52C8AE74D84525;
  localparam logic [255:0] HALF_R =
    256'h1FFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_CE864987AA03C629_8FA964573A6C2292;

  // lattice basis values
  localparam logic [127:0] BASIS_U = 128'h1A509F7A53C2C6E6_2ACCF9DEC93F6111;
  localparam logic [127:0] BASIS_V = 128'h7D440C6AFFBB3A93_0B7A31305466F77E;

  // r0 = 2^254 - r, which is 2^128 minus the low half of r
  localparam logic [128:0] R0_W = {1'b1, 128'h0} - {1'b0, ORD_R[127:0]};
  localparam logic [127:0] R0   = R0_W[127:0];

  // pipeline depth
  localparam int NST = 21;

  // stage enables of one pipelined multiplier
  typedef logic [3:0] mul_en_t;

  // one conditional subtraction of r
  function automatic logic [255:0] csub_r(input logic [255:0] k);
    logic [256:0] d;
    d = {1'b0, k} - {1'b0, ORD_R};
    return d[256] ? k : d[255:0];
  endfunction

endpackage

// ----- rtl/glv_if.sv -----
// ----------------------------------------------------------------------------
// glv_in_if / glv_out_if
// Valid/ready channels for scalar words and split results.
// ----------------------------------------------------------------------------
interface glv_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] scalar_w0;
  logic [63:0] scalar_w1;
  logic [63:0] scalar_w2;
  logic [63:0] scalar_w3;

  modport source (output valid, scalar_w0, scalar_w1, scalar_w2, scalar_w3,
                  input ready);
  modport sink   (input valid, scalar_w0, scalar_w1, scalar_w2, scalar_w3,
                  output ready);
endinterface

interface glv_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] half0_lo;
  logic signed [63:0] half0_hi;
  logic        [63:0] half1_lo;
  logic signed [63:0] half1_hi;

  modport source (output valid, half0_lo, half0_hi, half1_lo, half1_hi,
                  input ready);
  modport sink   (input valid, half0_lo, half0_hi, half1_lo, half1_hi,
                  output ready);
endinterface

// ----- rtl/glv_scalar_split.sv -----
// ----------------------------------------------------------------------------
// glv_scalar_split
// Reduces a scalar mod r and splits it into two signed 128-bit halves.
// ----------------------------------------------------------------------------
// channel   modport  payload
// in_ch     sink     scalar_w0..scalar_w3, 64 bits each
// out_ch    source   half0_lo/hi, half1_lo/hi, 64 bits each
//
// one word per cycle sustained while out_ch is ready; 21 register stages:
// four reduction stages, three four-stage multiplier banks and five for
// sums, quotients and output
// each stage holds its word until the next stage frees, so bubbles close up
// under backpressure and input is taken while a result waits
// rst_n clears the stage valid bits only
module glv_scalar_split (
  input logic       clk,
  input logic       rst_n,
  glv_in_if.sink    in_ch,
  glv_out_if.source out_ch
);
  import glv_pkg::*;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic [NST-1:0] v_in;

  logic [255:0] kr_r   [4];
  logic [255:0] kr_nxt [4];
  logic [127:0] kd_r   [16];
  logic [255:0] pcl, pch, pdl, pdh;
  logic [383:0] zc_r, zd_r;
  logic [253:0] z0c_r [5];
  logic [253:0] z0d_r [5];
  logic [127:0] yc_r  [6];
  logic [127:0] yd_r  [6];
  logic [255:0] ptc, ptd;
  logic [256:0] sc, sd;
  logic         flc_r, fld_r;
  logic [127:0] qc_r, qd_r;
  logic [255:0] pdu, pcv, pdv, pcu;
  logic [127:0] h0_r, h1_r;

  // stage enables, from the output back
  always_comb begin
    en[NST-1] = ~v_r[NST-1] | out_ch.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = ~v_r[i] | en[i+1];
    end
  end

  assign v_in        = {v_r[NST-2:0], in_ch.valid};
  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_in[i];
      end
    end
  end

  // reduction mod r, one conditional subtraction a stage
  always_comb begin
    kr_nxt[0] = csub_r({in_ch.scalar_w3, in_ch.scalar_w2,
                        in_ch.scalar_w1, in_ch.scalar_w0});
    for (int i = 1; i < 4; i++) begin
      kr_nxt[i] = csub_r(kr_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (en[i]) kr_r[i] <= kr_nxt[i];
    end
  end

  // low half of k carried to the output stage
  always_ff @(posedge clk) begin
    if (en[4]) kd_r[0] <= kr_r[3][127:0];
    for (int j = 1; j < 16; j++) begin
      if (en[4+j]) kd_r[j] <= kd_r[j-1];
    end
  end

  // k * v and k * u, each as two 128-bit halves of k
  glv_mul u_mul_cl (.clk(clk), .en(en[7:4]), .a(kr_r[3][127:0]),   .b(BASIS_V), .p(pcl));
  glv_mul u_mul_ch (.clk(clk), .en(en[7:4]), .a(kr_r[3][255:128]), .b(BASIS_V), .p(pch));
  glv_mul u_mul_dl (.clk(clk), .en(en[7:4]), .a(kr_r[3][127:0]),   .b(BASIS_U), .p(pdl));
  glv_mul u_mul_dh (.clk(clk), .en(en[7:4]), .a(kr_r[3][255:128]), .b(BASIS_U), .p(pdh));

  // z = k * e + (r - 1) / 2, then y = floor(z / 2^254) + 1
  always_ff @(posedge clk) begin
    if (en[8]) begin
      zc_r <= {128'h0, pcl} + {pch, 128'h0} + {128'h0, HALF_R};
      zd_r <= {128'h0, pdl} + {pdh, 128'h0} + {128'h0, HALF_R};
    end
    if (en[9]) begin
      yc_r[0]  <= zc_r[381:254] + 128'd1;
      yd_r[0]  <= zd_r[381:254] + 128'd1;
      z0c_r[0] <= zc_r[253:0];
      z0d_r[0] <= zd_r[253:0];
    end
    for (int j = 1; j < 6; j++) begin
      if (en[9+j]) begin
        yc_r[j] <= yc_r[j-1];
        yd_r[j] <= yd_r[j-1];
      end
    end
    for (int j = 1; j < 5; j++) begin
      if (en[9+j]) begin
        z0c_r[j] <= z0c_r[j-1];
        z0d_r[j] <= z0d_r[j-1];
      end
    end
  end

  // y * r0 for the rounding correction
  glv_mul u_mul_tc (.clk(clk), .en(en[13:10]), .a(yc_r[0]), .b(R0), .p(ptc));
  glv_mul u_mul_td (.clk(clk), .en(en[13:10]), .a(yd_r[0]), .b(R0), .p(ptd));

  // correction test and corrected quotients
  assign sc = {3'b0, z0c_r[4]} + {1'b0, ptc};
  assign sd = {3'b0, z0d_r[4]} + {1'b0, ptd};

  always_ff @(posedge clk) begin
    if (en[14]) begin
      flc_r <= (sc[256:254] == 3'b000);
      fld_r <= (sd[256:254] == 3'b000);
    end
    if (en[15]) begin
      qc_r <= yc_r[5] - {127'h0, flc_r};
      qd_r <= yd_r[5] - {127'h0, fld_r};
    end
  end

  // quotient times basis products
  glv_mul u_mul_du (.clk(clk), .en(en[19:16]), .a(qd_r), .b(BASIS_U), .p(pdu));
  glv_mul u_mul_cv (.clk(clk), .en(en[19:16]), .a(qc_r), .b(BASIS_V), .p(pcv));
  glv_mul u_mul_dv (.clk(clk), .en(en[19:16]), .a(qd_r), .b(BASIS_V), .p(pdv));
  glv_mul u_mul_cu (.clk(clk), .en(en[19:16]), .a(qc_r), .b(BASIS_U), .p(pcu));

  // output register: k0 = k - d*u - c*v, k1 = d*v - c*u
  always_ff @(posedge clk) begin
    if (en[20]) begin
      h0_r <= kd_r[15] - pdu[127:0] - pcv[127:0];
      h1_r <= pdv[127:0] - pcu[127:0];
    end
  end

  assign out_ch.valid    = v_r[NST-1];
  assign out_ch.half0_lo = h0_r[63:0];
  assign out_ch.half0_hi = $signed(h0_r[127:64]);
  assign out_ch.half1_lo = h1_r[63:0];
  assign out_ch.half1_hi = $signed(h1_r[127:64]);

`ifndef ASSERT_OFF
  // the fourth subtraction leaves k below r
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (kr_r[3] < ORD_R))
    else $error("scalar not reduced after four subtractions");

  // a reduced scalar keeps z below 2^382
  a_z_top: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[8] |-> (zc_r[383:382] == 2'b00 && zd_r[383:382] == 2'b00))
    else $error("quotient product overflows");

  // input stalls only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with a free stage");
`endif

endmodule

// ----- rtl/glv_mul.sv -----
// ----------------------------------------------------------------------------
// glv_mul
// Four-stage 128 x 128 multiplier built from 32 x 32 partial products.
// ----------------------------------------------------------------------------
module glv_mul (
  input  logic             clk,
  input  glv_pkg::mul_en_t en,
  input  logic [127:0]     a,
  input  logic [127:0]     b,
  output logic [255:0]     p
);
  import glv_pkg::*;

  logic [63:0]  pp_r  [4][4];
  logic [159:0] row_r [4];
  logic [191:0] pr_r  [2];
  logic [255:0] p_r;
  logic [159:0] row_nxt [4];
  logic [191:0] pr_nxt  [2];

  // partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp_r[i][j] <= a[32*i +: 32] * b[32*j +: 32];
        end
      end
    end
  end

  // row sums and pair sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_nxt[i] = 160'(pp_r[i][0]) + (160'(pp_r[i][1]) << 32)
                 + (160'(pp_r[i][2]) << 64) + (160'(pp_r[i][3]) << 96);
    end
    for (int i = 0; i < 2; i++) begin
      pr_nxt[i] = 192'(row_r[2*i]) + (192'(row_r[2*i+1]) << 32);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) row_r <= row_nxt;
    if (en[2]) pr_r  <= pr_nxt;
    if (en[3]) p_r   <= 256'(pr_r[0]) + (256'(pr_r[1]) << 64);
  end

  assign p = p_r;

endmodule

// ----- tb/tb_glv_scalar_split.sv -----
// ----------------------------------------------------------------------------
// tb_glv_scalar_split
// Streams scalars into the splitter and checks both signed halves of each
// result against a behavioral model of reduction and rounded division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_glv_scalar_split;
  import glv_pkg::*;

  typedef struct packed {
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } scalar_word_t;

  typedef struct packed {
    logic [63:0] h1_hi;
    logic [63:0] h1_lo;
    logic [63:0] h0_hi;
    logic [63:0] h0_lo;
  } split_word_t;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   n_err;

  scalar_word_t pending_scalars[$];
  split_word_t  expected_splits[$];

  glv_in_if  in_ch();
  glv_out_if out_ch();

  glv_scalar_split uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounded quotient round(k*e/r) mod 2^128 via the 2^254 shortcut
  function automatic logic [127:0] round_quot(input logic [255:0] k,
                                              input logic [127:0] e);
    logic [383:0] z;
    logic [127:0] y;
    logic [255:0] z0;
    logic [256:0] s;
    z  = 384'(k) * 384'(e) + 384'(HALF_R);
    y  = z[381:254] + 128'd1;
    z0 = {2'b00, z[253:0]};
    s  = 257'(z0) + 257'(256'(y) * 256'(R0));
    if (s[256:254] == 3'd0) y = y - 128'd1;
    return y;
  endfunction

  // full split of one scalar
  function automatic split_word_t calc_halves(input scalar_word_t sw);
    logic [255:0] k;
    logic [127:0] c;
    logic [127:0] d;
    logic [127:0] h0;
    logic [127:0] h1;
    split_word_t  r;
    k = sw;
    for (int i = 0; i < 4; i++) if (k >= ORD_R) k = k - ORD_R;
    c  = round_quot(k, BASIS_V);
    d  = round_quot(k, BASIS_U);
    h0 = k[127:0] - d * BASIS_U - c * BASIS_V;
    h1 = d * BASIS_V - c * BASIS_U;
    r.h0_lo = h0[63:0];
    r.h0_hi = h0[127:64];
    r.h1_lo = h1[63:0];
    r.h1_hi = h1[127:64];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // word that is zero, all ones, a single set bit or random
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'(1) << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  function automatic scalar_word_t rand_scalar();
    scalar_word_t s;
    logic [255:0] v;
    case ($urandom_range(0, 7))
      0: begin
        // near r or its multiples
        v = ORD_R * $urandom_range(1, 3) + 256'($signed(32'($urandom_range(0, 64)) - 32));
        s = v;
      end
      1: begin
        s.w0 = pick64(); s.w1 = pick64(); s.w2 = pick64(); s.w3 = pick64();
      end
      default: begin
        s.w0 = rand64(); s.w1 = rand64(); s.w2 = rand64(); s.w3 = rand64();
      end
    endcase
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_splits.push_back(calc_halves(
          {in_ch.scalar_w3, in_ch.scalar_w2, in_ch.scalar_w1, in_ch.scalar_w0}));
      if (pending_scalars.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        scalar_word_t s;
        s = pending_scalars.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.scalar_w0 <= s.w0;
        in_ch.scalar_w1 <= s.w1;
        in_ch.scalar_w2 <= s.w2;
        in_ch.scalar_w3 <= s.w3;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        split_word_t got;
        split_word_t exp_w;
        got = {out_ch.half1_hi, out_ch.half1_lo, out_ch.half0_hi, out_ch.half0_lo};
        if (expected_splits.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          n_err++;
        end else begin
          exp_w = expected_splits.pop_front();
          if (got.h0_lo !== exp_w.h0_lo)
            $display("%0t: half0_lo exp %h got %h", $time, exp_w.h0_lo, got.h0_lo);
          if (got.h0_hi !== exp_w.h0_hi)
            $display("%0t: half0_hi exp %h got %h", $time, exp_w.h0_hi, got.h0_hi);
          if (got.h1_lo !== exp_w.h1_lo)
            $display("%0t: half1_lo exp %h got %h", $time, exp_w.h1_lo, got.h1_lo);
          if (got.h1_hi !== exp_w.h1_hi)
            $display("%0t: half1_hi exp %h got %h", $time, exp_w.h1_hi, got.h1_hi);
          if (got !== exp_w) n_err++;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    scalar_word_t s;
    clk = 1'b0;
    rst_n = 1'b0;
    n_err = 0;
    src_idle_pct = 11;
    snk_idle_pct = 88;
    in_ch.valid = 1'b0;
    in_ch.scalar_w0 = '0;
    in_ch.scalar_w1 = '0;
    in_ch.scalar_w2 = '0;
    in_ch.scalar_w3 = '0;
    out_ch.ready = 1'b0;

    // directed: zero, ones, r and neighbors, half r, 2^254, single lanes
    pending_scalars.push_back('0);
    pending_scalars.push_back(256'd1);
    pending_scalars.push_back('1);
    pending_scalars.push_back(ORD_R);
    pending_scalars.push_back(ORD_R - 256'd1);
    pending_scalars.push_back(ORD_R + 256'd1);
    pending_scalars.push_back(HALF_R);
    pending_scalars.push_back(HALF_R + 256'd1);
    pending_scalars.push_back(ORD_R * 2);
    pending_scalars.push_back(ORD_R * 3);
    pending_scalars.push_back(ORD_R * 3 - 256'd1);
    pending_scalars.push_back(256'(1) << 254);
    pending_scalars.push_back(256'(1) << 255);
    pending_scalars.push_back({4{64'h5555555555555555}});
    pending_scalars.push_back({4{64'hAAAAAAAAAAAAAAAA}});
    pending_scalars.push_back({64'd0, 64'd0, 64'd0, 64'hFFFFFFFFFFFFFFFF});
    pending_scalars.push_back({64'hFFFFFFFFFFFFFFFF, 64'd0, 64'd0, 64'd0});
    pending_scalars.push_back(256'(BASIS_U));
    pending_scalars.push_back(256'(BASIS_V));
    for (int i = 0; i < 340; i++) pending_scalars.push_back(rand_scalar());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_scalars.size() > 0) @(posedge clk);
    src_idle_pct = 88;
    snk_idle_pct = 11;
    for (int i = 0; i < 350; i++) pending_scalars.push_back(rand_scalar());
    while (pending_scalars.size() > 0) @(posedge clk);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int i = 0; i < 350; i++) pending_scalars.push_back(rand_scalar());
    while (pending_scalars.size() > 0 || in_ch.valid) @(posedge clk);
    @(posedge clk);
    while (expected_splits.size() > 0) @(posedge clk);
    repeat (2 * NST + 10) @(posedge clk);

    if (n_err == 0 && expected_splits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/glv_pkg.sv
rtl/glv_if.sv
rtl/glv_mul.sv
rtl/glv_scalar_split.sv
tb/tb_glv_scalar_split.sv
